[rtl/core/cva_pkg.sv]
// ----------------------------------------------------------------------------
// cva_pkg: shared types and constants of the count vector ALU
// Holds the function codes, the operand width and the item and control
// structs that pass between the top level and the iterative unit.
// ----------------------------------------------------------------------------
package cva_pkg;

  // Width of a part count; values are taken modulo 2^COUNT_WIDTH.
  localparam int COUNT_WIDTH = 32;
  // Field width of the item values.
  localparam int FIELD_W = 32;
  // Effective operand width: counts are cut to both the field and count width.
  localparam int OP_W = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
  // Step counter width, able to hold OP_W itself.
  localparam int CNT_W = $clog2(OP_W + 1);

  // Function codes.
  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_SUB  = 2'd1;
  localparam logic [1:0] FN_MUL  = 2'd2;
  localparam logic [1:0] FN_MINQ = 2'd3;

  // One input item.
  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] first_value;
    logic [FIELD_W-1:0] second_value;
    logic [FIELD_W-1:0] multiplier;
    logic               last_element;
  } cva_in_t;

  // One result item.
  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    logic               result_last;
    logic               no_divisor;
  } cva_out_t;

  // Operands handed to the iterative unit.
  typedef struct packed {
    logic [1:0]      func;
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
    logic [OP_W-1:0] m;
  } cva_op_t;

  // Control from the top level to the unit.
  typedef struct packed {
    logic start;
    logic ack;
  } cva_ctrl_t;

  // Status from the unit to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } cva_stat_t;

endpackage

[rtl/core/count_vector_alu.sv]
// ----------------------------------------------------------------------------
// count_vector_alu: element-wise arithmetic on part count vectors
// Add, subtract and scale give one result item per element; minimum
// quotient keeps a running minimum and gives it on the last element.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                      Carries
//  -------  ---------------------------  ------------------------------------
//  req      req_valid, req_ready, req    one element pair, mode and last mark
//  rsp      rsp_valid, rsp_ready, rsp    one result, last mark, no-divisor flag
//
// Add and subtract take a single step of the shared adder; scale and minimum
// quotient take OP_W steps, the adder stepping one bit per cycle. Reset is
// synchronous and clears the sequencer, the result register valid and the
// minimum quotient state.
// A finished result waits in the output register while the next item is
// taken; a second result then holds the unit until the register frees.
// ----------------------------------------------------------------------------
module count_vector_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cva_pkg::cva_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cva_pkg::cva_out_t rsp
);
  import cva_pkg::*;

  cva_ctrl_t       ctrl;
  cva_stat_t       stat;
  cva_op_t         op;
  logic [OP_W-1:0] unit_result;

  // Details of the item in flight.
  logic [1:0]      pend_func;
  logic            pend_last;
  logic            pend_bnz;

  // Minimum quotient state.
  logic [OP_W-1:0] running_minimum, running_minimum_next;
  logic            divisor_seen, divisor_seen_next;

  logic            req_take;
  logic            slot_free;
  logic            load_rsp;
  cva_out_t        rsp_next;

  assign req_ready = stat.idle;
  assign req_take  = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  // Operands are cut to the count width.
  assign op.func = req.func;
  assign op.a    = req.first_value[OP_W-1:0];
  assign op.b    = req.second_value[OP_W-1:0];
  assign op.m    = req.multiplier[OP_W-1:0];

  cva_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .op     (op),
    .stat   (stat),
    .result (unit_result)
  );

  // Completion: fold a quotient into the minimum and decide on a result item.
  always_comb begin
    running_minimum_next = running_minimum;
    divisor_seen_next    = divisor_seen;
    load_rsp             = 1'b0;
    ctrl.start           = req_take;
    ctrl.ack             = 1'b0;
    rsp_next.result_value = FIELD_W'(unit_result);
    rsp_next.result_last  = pend_last;
    rsp_next.no_divisor   = 1'b0;
    if (stat.done) begin
      if (pend_func != FN_MINQ) begin
        if (slot_free) begin
          load_rsp = 1'b1;
          ctrl.ack = 1'b1;
        end
      end else begin
        if (pend_bnz && (!divisor_seen || unit_result < running_minimum)) begin
          running_minimum_next = unit_result;
        end
        if (pend_bnz) begin
          divisor_seen_next = 1'b1;
        end
        rsp_next.result_value = divisor_seen_next ? FIELD_W'(running_minimum_next) : '0;
        rsp_next.no_divisor   = !divisor_seen_next;
        if (!pend_last) begin
          ctrl.ack = 1'b1;
        end else if (slot_free) begin
          load_rsp             = 1'b1;
          ctrl.ack             = 1'b1;
          running_minimum_next = '0;
          divisor_seen_next    = 1'b0;
        end
      end
    end
  end

  // Item details, state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid       <= 1'b0;
      running_minimum <= '0;
      divisor_seen    <= 1'b0;
    end else begin
      if (ctrl.ack) begin
        running_minimum <= running_minimum_next;
        divisor_seen    <= divisor_seen_next;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_take) begin
      pend_func <= req.func;
      pend_last <= req.last_element;
      pend_bnz  <= (op.b != '0);
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

endmodule

[rtl/core/cva_unit.sv]
// ----------------------------------------------------------------------------
// cva_unit: iterative arithmetic unit
// One shared adder/subtractor serves add and subtract in a single step,
// scaling by shift-and-add and division by restoring steps, one bit a cycle.
// ----------------------------------------------------------------------------
module cva_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  cva_pkg::cva_ctrl_t      ctrl,
  input  cva_pkg::cva_op_t        op,
  output cva_pkg::cva_stat_t      stat,
  output logic [cva_pkg::OP_W-1:0] result
);
  import cva_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       fn, fn_next;
  logic [OP_W-1:0]  acc, acc_next;
  logic [OP_W-1:0]  shr, shr_next;
  logic [OP_W-1:0]  opnd, opnd_next;

  // Shared adder operands and sum.
  logic [OP_W:0]    add_x;
  logic [OP_W:0]    add_y;
  logic             add_sub;
  logic [OP_W+1:0]  add_sum;
  logic             no_borrow;

  // Select what the shared adder works on for the current function.
  always_comb begin
    add_x   = {1'b0, acc};
    add_y   = {1'b0, opnd};
    add_sub = 1'b0;
    case (fn)
      FN_ADD: begin
        add_sub = 1'b0;
      end
      FN_SUB: begin
        add_sub = 1'b1;
      end
      FN_MUL: begin
        // Product so far doubled, plus the operand when the multiplier bit is set.
        add_x = {1'b0, acc[OP_W-2:0], 1'b0};
        add_y = shr[OP_W-1] ? {1'b0, opnd} : '0;
      end
      default: begin
        // Partial remainder with the next dividend bit, minus the divisor.
        add_x   = {acc, shr[OP_W-1]};
        add_sub = 1'b1;
      end
    endcase
  end

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + {{(OP_W+1){1'b0}}, add_sub};
  assign no_borrow = add_sum[OP_W+1];

  // Sequencer and operand registers.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    fn_next    = fn;
    acc_next   = acc;
    shr_next   = shr;
    opnd_next  = opnd;
    case (state)
      S_IDLE: begin
        if (ctrl.start) begin
          fn_next    = op.func;
          state_next = S_RUN;
          case (op.func)
            FN_ADD, FN_SUB: begin
              acc_next  = op.a;
              opnd_next = op.b;
              cnt_next  = CNT_W'(1);
            end
            FN_MUL: begin
              acc_next  = '0;
              shr_next  = op.m;
              opnd_next = op.a;
              cnt_next  = CNT_W'(OP_W);
            end
            default: begin
              acc_next  = '0;
              shr_next  = op.a;
              opnd_next = op.b;
              cnt_next  = CNT_W'(OP_W);
            end
          endcase
        end
      end
      S_RUN: begin
        cnt_next = cnt - CNT_W'(1);
        case (fn)
          FN_ADD, FN_SUB: begin
            acc_next = add_sum[OP_W-1:0];
          end
          FN_MUL: begin
            acc_next = add_sum[OP_W-1:0];
            shr_next = {shr[OP_W-2:0], 1'b0};
          end
          default: begin
            acc_next = no_borrow ? add_sum[OP_W-1:0] : add_x[OP_W-1:0];
            shr_next = {shr[OP_W-2:0], no_borrow};
          end
        endcase
        if (cnt == CNT_W'(1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ctrl.ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    cnt  <= cnt_next;
    fn   <= fn_next;
    acc  <= acc_next;
    shr  <= shr_next;
    opnd <= opnd_next;
  end

  // The quotient collects in the shift register, every other result in acc.
  assign result    = (fn == FN_MINQ) ? shr : acc;
  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule

[rtl/core/cva_checker.sv]
// ----------------------------------------------------------------------------
// cva_checker: port-level checks of the count vector ALU
// Watches the top level's ports and flags behaviour the design never shows.
// ----------------------------------------------------------------------------
module cva_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input cva_pkg::cva_out_t rsp
);
  import cva_pkg::*;

  // The unit is busy in the cycle after it takes an item.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req_ready stayed high after an item was taken");

  // A missing divisor always comes with a zero result.
  a_nodiv_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.no_divisor) |-> (rsp.result_value == '0))
    else $error("no_divisor set with a nonzero result");

  // A no-divisor flag only appears on the last element.
  a_nodiv_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.no_divisor) |-> rsp.result_last)
    else $error("no_divisor set on an item that is not last");

  // A stalled result item holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result item changed or vanished");

endmodule

bind count_vector_alu cva_checker u_cva_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
